[design/bmf_pkg.sv]
// ============================================================================
// bmf_pkg - shared constants and types for the box mean filter
// Widths, register codes, divider reciprocals and the result record.
// ============================================================================
package bmf_pkg;

    // Line store geometry
    localparam int MAX_WIDTH = 1024;
    localparam int LINE_ROWS = 4;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int WSEL_W    = $clog2(LINE_ROWS);
    localparam bit WIDE_OK   = (LINE_ROWS >= 4);

    // Field and register widths
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int WIDTH_CAP = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int HEIGHT_CAP = 1024;
    localparam int MIN_DIM   = 5;
    localparam int COL_W     = $clog2(WIDTH_CAP);
    localparam int ROW_W     = CFG_W;
    localparam int OROW_W    = 10;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MODE  = CFG_IDX_W'(2);

    // Window arithmetic
    localparam int TAPS          = 5;
    localparam int FIRST_WIDE    = 0;
    localparam int FIRST_NARROW  = 2;
    localparam int CENTER_WIDE   = 2;
    localparam int CENTER_NARROW = 3;
    localparam int COL_SUM_W     = 11;
    localparam int WIN_SUM_W     = 13;

    // floor(s/9) and floor(s/25) as (s * m) >> 18, exact for s < 32768
    localparam int DIV_SHIFT = 18;
    localparam int RECIP_W   = 15;
    localparam int PROD_W    = WIN_SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_9  = RECIP_W'(29128);
    localparam logic [RECIP_W-1:0] RECIP_25 = RECIP_W'(10486);

    // Output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Per-item control from the counter block
    typedef struct packed {
        logic              take;
        logic              emit;
        logic              interior;
        logic              last;
        logic [WSEL_W-1:0] wsel;
        logic [COL_W-1:0]  col;
    } t_item_ctl;

    // One result item
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_result;

endpackage

[design/bmf_in_if.sv]
// ============================================================================
// bmf_in_if - input pixel channel
// Valid/ready handshake carrying one pixel or flush item.
// ============================================================================
interface bmf_in_if;
    import bmf_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;
    logic             flush;

    modport source (output valid, output pixel_in, output flush, input ready);
    modport sink   (input valid, input pixel_in, input flush, output ready);
endinterface

[design/bmf_out_if.sv]
// ============================================================================
// bmf_out_if - output pixel channel
// Valid/ready handshake carrying one filtered pixel.
// ============================================================================
interface bmf_out_if;
    import bmf_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

[design/box_mean_filter_3_or_5.sv]
// ============================================================================
// box_mean_filter_3_or_5 - streaming 3x3 / 5x5 box mean filter
// Line stores, a chain of column cells and a reciprocal divider produce the
// truncated window mean; pixels near the frame edge pass through unchanged.
// ============================================================================
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+---------------------------
//  i_in_ch  | in  | valid / ready   | pixel_in[7:0], flush
//  o_out_ch | out | valid / ready   | pixel_out[7:0], frame_last
//  i_cfg_*  | in  | i_cfg_we        | i_cfg_idx[1:0], i_cfg_data[10:0]
//
//  One item per clock while ready is high. A result reaches the queue via the
//  stage registers after the item completing its window; a frame's results
//  trail its pixels by R*width+R items (R = 1 or 2), which flush items push out.
//  Reset is synchronous; line store contents are never cleared, and a row is
//  always rewritten in a frame before it is used.
//  i_in_ch.ready drops while the 8-entry result queue plus results still in
//  the pipeline fill it; the pipeline itself never stalls.
//
module box_mean_filter_3_or_5 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bmf_in_if.sink                        i_in_ch,
    bmf_out_if.source                     o_out_ch,
    input  logic                          i_cfg_we,
    input  logic [bmf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bmf_pkg::CFG_W-1:0]     i_cfg_data
);
    import bmf_pkg::*;

    t_item_ctl             w_ctl;
    logic                  w_rad2;
    logic                  w_accept;
    logic                  w_ready;
    logic [FIFO_CNT_W-1:0] w_fifo_count;
    logic [FIFO_CNT_W:0]   w_committed;
    logic [ADDR_W-1:0]     w_addr;

    // stage 1: line store data in flight
    logic                  r_p1_valid;
    logic                  r_p1_emit;
    logic                  r_p1_interior;
    logic                  r_p1_last;
    logic [PIX_W-1:0]      r_p1_pix;
    logic [WSEL_W-1:0]     r_p1_wsel;

    // stage 2: window complete in the cell chain
    logic                  r_p2_valid;
    logic                  r_p2_interior;
    logic                  r_p2_last;

    // stage 3: window sum ready for the divider
    logic                  r_p3_valid;
    logic                  r_p3_interior;
    logic                  r_p3_last;
    logic [WIN_SUM_W-1:0]  r_p3_sum;
    logic [PIX_W-1:0]      r_p3_mid;

    logic [PIX_W-1:0]      w_rdata [LINE_ROWS];
    logic [PIX_W-1:0]      w_col [TAPS];
    logic [COL_SUM_W-1:0]  w_col_sum;
    logic [PIX_W-1:0]      w_cell_mid [TAPS+1];
    logic [WIN_SUM_W-1:0]  w_cell_sum [TAPS+1];
    logic [WIN_SUM_W-1:0]  w_win_sum;
    logic [PIX_W-1:0]      w_center;
    logic [PROD_W-1:0]     w_prod;
    logic [PIX_W-1:0]      w_quot;
    t_result               w_result;
    t_result               w_head;

    // input handshake: room for every result already committed
    assign w_committed = (FIFO_CNT_W+1)'(w_fifo_count) +
                         (FIFO_CNT_W+1)'(r_p1_valid & r_p1_emit) +
                         (FIFO_CNT_W+1)'(r_p2_valid) +
                         (FIFO_CNT_W+1)'(r_p3_valid);
    assign w_ready       = w_committed < (FIFO_CNT_W+1)'(FIFO_DEPTH);
    assign i_in_ch.ready = w_ready;
    assign w_accept      = i_in_ch.valid & w_ready;

    // counters and configuration
    bmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_flush    (i_in_ch.flush),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_ctl      (w_ctl),
        .o_rad2     (w_rad2)
    );

    // line stores, one RAM per row; only pixels are written
    assign w_addr = ADDR_W'(w_ctl.col);

    for (genvar k = 0; k < LINE_ROWS; k++) begin : g_line
        bmf_ram #(
            .DATA_W (PIX_W),
            .DEPTH  (MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (w_ctl.take & ~i_in_ch.flush & (w_ctl.wsel == WSEL_W'(k))),
            .i_waddr (w_addr),
            .i_wdata (i_in_ch.pixel_in),
            .i_re    (w_ctl.take),
            .i_raddr (w_addr),
            .o_rdata (w_rdata[k])
        );
    end

    // stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p1_emit  <= 1'b0;
        end else begin
            r_p1_valid <= w_ctl.take;
            r_p1_emit  <= w_ctl.emit;
        end
        r_p1_interior <= w_ctl.interior;
        r_p1_last     <= w_ctl.last;
        r_p1_pix      <= i_in_ch.pixel_in;
        r_p1_wsel     <= w_ctl.wsel;
    end

    // new column: rows y-4..y-1 from the line stores, row y from the item
    for (genvar r = 0; r < TAPS - 1; r++) begin : g_tap
        localparam int D = (TAPS - 1 - r) % LINE_ROWS;
        logic [WSEL_W-1:0] w_sel;
        assign w_sel = (r_p1_wsel >= WSEL_W'(D)) ? r_p1_wsel - WSEL_W'(D)
                                                 : r_p1_wsel + WSEL_W'(LINE_ROWS - D);
        assign w_col[r] = w_rdata[w_sel];
    end
    assign w_col[TAPS-1] = r_p1_pix;

    // column sum over the rows of the window, and its center pixel
    assign w_col_sum = w_rad2 ?
        (COL_SUM_W'(w_col[0]) + COL_SUM_W'(w_col[1]) + COL_SUM_W'(w_col[2]) +
         COL_SUM_W'(w_col[3]) + COL_SUM_W'(w_col[4])) :
        (COL_SUM_W'(w_col[2]) + COL_SUM_W'(w_col[3]) + COL_SUM_W'(w_col[4]));
    assign w_cell_mid[TAPS] = w_rad2 ? w_col[CENTER_WIDE] : w_col[CENTER_NARROW];
    assign w_cell_sum[TAPS] = '0;

    // cell chain: cell k holds the sum of the newest TAPS-k columns
    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        bmf_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (r_p1_valid),
            .i_col_sum (w_col_sum),
            .i_sum     (w_cell_sum[k+1]),
            .i_mid     (w_cell_mid[k+1]),
            .o_sum     (w_cell_sum[k]),
            .o_mid     (w_cell_mid[k])
        );
    end

    // stage 2 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else begin
            r_p2_valid <= r_p1_valid & r_p1_emit;
        end
        r_p2_interior <= r_p1_interior;
        r_p2_last     <= r_p1_last;
    end

    // window sum and original center pixel
    assign w_win_sum = w_rad2 ? w_cell_sum[FIRST_WIDE] : w_cell_sum[FIRST_NARROW];
    assign w_center  = w_rad2 ? w_cell_mid[CENTER_WIDE] : w_cell_mid[CENTER_NARROW];

    // stage 3 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_valid <= 1'b0;
        end else begin
            r_p3_valid <= r_p2_valid;
        end
        r_p3_interior <= r_p2_interior;
        r_p3_last     <= r_p2_last;
        r_p3_sum      <= w_win_sum;
        r_p3_mid      <= w_center;
    end

    // divide by 9 or 25 through a reciprocal multiply
    assign w_prod = PROD_W'(r_p3_sum) * PROD_W'(w_rad2 ? RECIP_25 : RECIP_9);
    assign w_quot = w_prod[DIV_SHIFT +: PIX_W];

    assign w_result.pixel = r_p3_interior ? w_quot : r_p3_mid;
    assign w_result.last  = r_p3_last;

    // result queue
    bmf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_p3_valid),
        .i_data  (w_result),
        .i_ready (o_out_ch.ready),
        .o_valid (o_out_ch.valid),
        .o_data  (w_head),
        .o_count (w_fifo_count)
    );

    assign o_out_ch.pixel_out  = w_head.pixel;
    assign o_out_ch.frame_last = w_head.last;
endmodule

[design/bmf_ram.sv]
// ============================================================================
// bmf_ram - generic single-write, single-read RAM
// Registered read; a read and write to the same address return the old data.
// ============================================================================
module bmf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // read-first port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[design/bmf_cell.sv]
// ============================================================================
// bmf_cell - one column cell of the window chain
// Adds the new column sum to the partial sum from its neighbor and passes
// the center pixel along, once per item.
// ============================================================================
module bmf_cell (
    input  logic                          i_clk,
    input  logic                          i_shift,
    input  logic [bmf_pkg::COL_SUM_W-1:0] i_col_sum,
    input  logic [bmf_pkg::WIN_SUM_W-1:0] i_sum,
    input  logic [bmf_pkg::PIX_W-1:0]     i_mid,
    output logic [bmf_pkg::WIN_SUM_W-1:0] o_sum,
    output logic [bmf_pkg::PIX_W-1:0]     o_mid
);
    import bmf_pkg::*;

    logic [WIN_SUM_W-1:0] r_sum;
    logic [PIX_W-1:0]     r_mid;

    // partial window sum: neighbor's sum from last item plus this column
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sum <= i_sum + WIN_SUM_W'(i_col_sum);
            r_mid <= i_mid;
        end
    end

    assign o_sum = r_sum;
    assign o_mid = r_mid;
endmodule

[design/bmf_ctrl.sv]
// ============================================================================
// bmf_ctrl - frame counters and configuration registers
// Tracks input and output raster positions, decides which items are taken,
// which produce a result, and whether a result is interior or border.
// ============================================================================
module bmf_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_flush,
    input  logic                          i_cfg_we,
    input  logic [bmf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bmf_pkg::CFG_W-1:0]     i_cfg_data,
    output bmf_pkg::t_item_ctl            o_ctl,
    output logic                          o_rad2
);
    import bmf_pkg::*;

    logic [CFG_W-1:0]  r_width;
    logic [CFG_W-1:0]  r_height;
    logic              r_mode;
    logic [COL_W-1:0]  r_in_col;
    logic [ROW_W-1:0]  r_in_row;
    logic [WSEL_W-1:0] r_wsel;
    logic [COL_W-1:0]  r_out_col;
    logic [OROW_W-1:0] r_out_row;

    logic              w_rad2;
    logic [CFG_W-1:0]  w_rad;
    logic [CFG_W-1:0]  w_x;
    logic [CFG_W-1:0]  w_ox;
    logic [CFG_W-1:0]  w_oy;
    logic              w_take;
    logic              w_emit;
    logic              w_interior;
    logic              w_in_end;
    logic              w_out_end;
    logic              w_last;
    logic              w_cfg_hit;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] res;
        if (v < CFG_W'(MIN_DIM)) begin
            res = CFG_W'(MIN_DIM);
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // window radius and raster positions
    assign w_rad2 = r_mode & WIDE_OK;
    assign w_rad  = w_rad2 ? CFG_W'(2) : CFG_W'(1);
    assign w_x    = CFG_W'(r_in_col);
    assign w_ox   = CFG_W'(r_out_col);
    assign w_oy   = CFG_W'(r_out_row);

    // flush only counts after the last pixel; pixels only before it
    assign w_take = i_accept & (i_flush ? (r_in_row >= r_height) : (r_in_row < r_height));

    assign w_emit = (r_in_row > w_rad) || ((r_in_row == w_rad) && (w_x >= w_rad));

    assign w_interior = (w_oy >= w_rad) && ((w_oy + w_rad) < r_height) &&
                        (w_ox >= w_rad) && ((w_ox + w_rad) < r_width);

    assign w_in_end  = (w_x + CFG_W'(1)) >= r_width;
    assign w_out_end = (w_ox + CFG_W'(1)) >= r_width;
    assign w_last    = w_out_end && ((w_oy + CFG_W'(1)) >= r_height);

    assign w_cfg_hit = i_cfg_we && ((i_cfg_idx == CFG_IMAGE_WIDTH) ||
                                    (i_cfg_idx == CFG_IMAGE_HEIGHT) ||
                                    (i_cfg_idx == CFG_WINDOW_MODE));

    // registers and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= CFG_W'(RESET_WIDTH);
            r_height  <= CFG_W'(RESET_HEIGHT);
            r_mode    <= 1'b0;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_wsel    <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (w_cfg_hit) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH: begin
                    r_width <= clamp_dim(i_cfg_data, CFG_W'(WIDTH_CAP));
                end
                CFG_IMAGE_HEIGHT: begin
                    r_height <= clamp_dim(i_cfg_data, CFG_W'(HEIGHT_CAP));
                end
                CFG_WINDOW_MODE: begin
                    r_mode <= i_cfg_data[0];
                end
                default: begin
                    r_mode <= r_mode;
                end
            endcase
            // any register write starts a new frame
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_wsel    <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (w_take) begin
            // input position
            if (w_in_end) begin
                r_in_col <= '0;
                r_in_row <= r_in_row + ROW_W'(1);
                r_wsel   <= (r_wsel == WSEL_W'(LINE_ROWS - 1)) ? '0 : r_wsel + WSEL_W'(1);
            end else begin
                r_in_col <= r_in_col + COL_W'(1);
            end
            // output position; the frame's last result restarts everything
            if (w_emit) begin
                if (w_out_end) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + OROW_W'(1);
                end else begin
                    r_out_col <= r_out_col + COL_W'(1);
                end
                if (w_last) begin
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_wsel    <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end
            end
        end
    end

    assign o_ctl.take     = w_take;
    assign o_ctl.emit     = w_emit;
    assign o_ctl.interior = w_interior;
    assign o_ctl.last     = w_last;
    assign o_ctl.wsel     = r_wsel;
    assign o_ctl.col      = r_in_col;
    assign o_rad2         = w_rad2;
endmodule

[design/bmf_fifo.sv]
// ============================================================================
// bmf_fifo - output result queue
// Small register queue that holds finished items until the sink takes them.
// ============================================================================
module bmf_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  bmf_pkg::t_result               i_data,
    input  logic                           i_ready,
    output logic                           o_valid,
    output bmf_pkg::t_result               o_data,
    output logic [bmf_pkg::FIFO_CNT_W-1:0] o_count
);
    import bmf_pkg::*;

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid & i_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + FIFO_CNT_W'(1);
                2'b01:   r_count <= r_count - FIFO_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
endmodule

[tb/sv/box_mean_filter_3_or_5_test.sv]
// ============================================================================
// box_mean_filter_3_or_5_test - self-checking bench for the box mean filter
// Streams small frames, one wide and one very tall partial frame, and
// random noise items through the block. A scoreboard predicts every output
// pixel from its own copy of the line stores and window taps, and the
// results are checked in order as they leave the output channel.
// ============================================================================
module box_mean_filter_3_or_5_test;
    import bmf_pkg::*;

    localparam int unsigned AREA_3X3      = 9;
    localparam int unsigned AREA_5X5      = 25;
    localparam int unsigned RANDOM_ITEMS  = 500;
    localparam int unsigned WIDE_ROW      = 256;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned TAIL_CYCLES   = 20;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned STALL_LIMIT   = 2000;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

    typedef enum {FILL_RANDOM, FILL_FULL, FILL_ZERO, FILL_EXTREME} t_fill;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts output pixels and checks them in order
    // ------------------------------------------------------------------------
    class box_mean_board;
        logic [PIX_W-1:0] line_mem [LINE_ROWS][MAX_WIDTH];
        logic [PIX_W-1:0] taps [TAPS*TAPS];
        int unsigned      in_col, in_row, out_col, out_row;
        int unsigned      img_w, img_h;
        bit               window_5x5;
        t_result          expected_means [$];
        int unsigned      mismatches;

        function new();
            foreach (line_mem[r, c]) line_mem[r][c] = '0;
            img_w      = RESET_WIDTH;
            img_h      = RESET_HEIGHT;
            window_5x5 = 1'b0;
            mismatches = 0;
            clear_window();
        endfunction

        function void clear_window();
            foreach (taps[i]) taps[i] = '0;
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function int unsigned radius();
            return (window_5x5 && WIDE_OK) ? 2 : 1;
        endfunction

        function int unsigned pending();
            return expected_means.size();
        endfunction

        function logic [PIX_W-1:0] stored_pixel(int unsigned row, int unsigned col);
            if (col >= MAX_WIDTH) return '0;
            return line_mem[row % LINE_ROWS][col];
        endfunction

        function int unsigned clamp_dim(logic [CFG_W-1:0] data, int unsigned cap);
            if (data < MIN_DIM) return MIN_DIM;
            if (data > cap) return cap;
            return data;
        endfunction

        // register write; any valid index restarts the frame
        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:  img_w = clamp_dim(data, WIDTH_CAP);
                CFG_IMAGE_HEIGHT: img_h = clamp_dim(data, HEIGHT_CAP);
                CFG_WINDOW_MODE:  window_5x5 = data[0];
                default:          return;
            endcase
            clear_window();
        endfunction

        // accepted input item: update state, queue the output pixel it causes
        function void note_item(logic [PIX_W-1:0] pix, logic fl);
            int unsigned rad, x, y, ox, oy, lo, sum;
            bit          emit;
            t_result     res;
            rad = radius();
            x   = in_col;
            y   = in_row;
            // flush inside the frame, or pixel past its end: ignored
            if (fl ? (y < img_h) : (y >= img_h)) return;
            if (!fl) begin
                for (int r = 0; r < TAPS; r++)
                    for (int c = 0; c < TAPS - 1; c++)
                        taps[r*TAPS + c] = taps[r*TAPS + c + 1];
                for (int r = 0; r < TAPS - 1; r++)
                    taps[r*TAPS + TAPS - 1] = stored_pixel(y + 4*LINE_ROWS - (4 - r), x);
                taps[TAPS*TAPS - 1] = pix;
                if (x < MAX_WIDTH) line_mem[y % LINE_ROWS][x] = pix;
            end
            emit = (y > rad) || (y == rad && x >= rad);
            in_col = x + 1;
            if (in_col >= img_w) begin
                in_col = 0;
                in_row = y + 1;
            end
            if (!emit) return;

            oy = out_row;
            ox = out_col;
            if (oy >= rad && oy + rad < img_h && ox >= rad && ox + rad < img_w) begin
                lo  = 4 - 2*rad;
                sum = 0;
                for (int unsigned r = lo; r < TAPS; r++)
                    for (int unsigned c = lo; c < TAPS; c++)
                        sum += taps[r*TAPS + c];
                res.pixel = PIX_W'(sum / (rad == 1 ? AREA_3X3 : AREA_5X5));
            end else begin
                // border pixels pass through
                res.pixel = stored_pixel(oy, ox);
            end
            res.last = 1'b0;
            if (ox + 1 >= img_w) begin
                out_col = 0;
                if (oy + 1 >= img_h) begin
                    res.last = 1'b1;
                    clear_window();
                end else begin
                    out_row = oy + 1;
                end
            end else begin
                out_col = ox + 1;
            end
            expected_means.push_back(res);
        endfunction

        // accepted output item against the oldest expected pixel
        function void check_result(logic [PIX_W-1:0] pix, logic last);
            t_result want;
            if (expected_means.size() == 0) begin
                $display("%0t: unexpected output pixel_out=%0d frame_last=%0b",
                         $time, pix, last);
                mismatches++;
                return;
            end
            want = expected_means.pop_front();
            if (pix !== want.pixel) begin
                $display("%0t: pixel_out mismatch: expected %0d, actual %0d",
                         $time, want.pixel, pix);
                mismatches++;
            end
            if (last !== want.last) begin
                $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                         $time, want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    bmf_in_if  in_ch ();
    bmf_out_if out_ch ();

    box_mean_board sb = new();

    int          src_gap_pct;
    int          snk_stall_pct;
    int          hold_left;
    int unsigned random_items;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    box_mean_filter_3_or_5 dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------
    // offer one item, with random gaps, and hold it until accepted
    task automatic send_item(input logic [PIX_W-1:0] pix, input logic fl);
        @(negedge i_clk);
        while ($urandom_range(99) < src_gap_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.pixel_in = pix;
        in_ch.flush    = fl;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        sb.note_item(pix, fl);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // idle long enough for items with no output to leave the pipeline
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        sb.write_register(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(input t_fill fill);
        case (fill)
            FILL_FULL:    return '1;
            FILL_ZERO:    return '0;
            FILL_EXTREME: return $urandom_range(1) ? '1 : '0;
            default:      return PIX_W'($urandom);
        endcase
    endfunction

    // small random geometry, now and then below the legal range
    task automatic pick_config();
        settle();
        write_reg(CFG_IMAGE_WIDTH, ($urandom_range(15) == 0) ?
                  CFG_W'($urandom_range(4)) : CFG_W'($urandom_range(12, 5)));
        write_reg(CFG_IMAGE_HEIGHT, ($urandom_range(15) == 0) ?
                  CFG_W'($urandom_range(4)) : CFG_W'($urandom_range(8, 5)));
        write_reg(CFG_WINDOW_MODE, CFG_W'($urandom_range(2047)));
    endtask

    // one frame of pixels plus the flush tail; stop_early cuts it short
    task automatic run_frame(input t_fill fill, input int unsigned stop_early,
                             input bit pause_mid);
        int unsigned stop_at, tail;
        stop_at = (stop_early != 0) ? stop_early : sb.img_w * sb.img_h;
        for (int unsigned k = 0; k < stop_at; k++) begin
            if ($urandom_range(99) < 3) send_item(PIX_W'($urandom), 1'b1);
            if (pause_mid && k == stop_at / 2) drain_results();
            send_item(pick_pixel(fill), 1'b0);
            random_items++;
        end
        if (stop_early != 0) begin
            settle();
            return;
        end
        tail = sb.radius() * (sb.img_w + 1);
        for (int unsigned k = 0; k < tail; k++) begin
            if ($urandom_range(99) < 8) send_item(PIX_W'($urandom), 1'b0);
            send_item(PIX_W'($urandom), 1'b1);
            random_items++;
        end
        if ($urandom_range(99) < 5) send_item(PIX_W'($urandom), 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Result receiver with random stalls and a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready = 1'b0;
            end else begin
                out_ch.ready = ($urandom_range(99) >= snk_stall_pct);
            end
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.pixel_out, out_ch.frame_last);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long with no item moving on either channel
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("box_mean_filter_3_or_5_test NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned frame_no, cut, npix;
        t_fill       fill;
        in_ch.valid    = 1'b0;
        in_ch.pixel_in = '0;
        in_ch.flush    = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_IMAGE_WIDTH;
        i_cfg_data     = '0;
        i_rst_n        = 1'b0;
        src_gap_pct    = 20;
        snk_stall_pct  = 84;
        hold_left      = 0;
        random_items   = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: clamped 5x5 frame of extreme pixels, 3x3 window
        write_reg(CFG_IMAGE_WIDTH, '0);
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(3));
        write_reg(CFG_WINDOW_MODE, CFG_W'(11'h7FE));
        write_reg(CFG_UNUSED, '1);
        for (int k = 0; k < 25; k++) begin
            if (k == 12) send_item('1, 1'b1);              // flush mid-frame
            send_item((k % 4 == 3) ? '0 : '1, 1'b0);
        end
        send_item(PIX_W'(8'hA5), 1'b0);                    // pixel past frame end
        for (int k = 0; k < 6; k++) send_item((k % 2) ? '1 : '0, 1'b1);

        // wide rows, cut short after the first interior outputs
        settle();
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(WIDE_ROW));
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(5));
        write_reg(CFG_WINDOW_MODE, '0);
        run_frame(FILL_RANDOM, 2*WIDE_ROW + 16, 1'b0);

        // tallest frame with the 5x5 window, cut short
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(5));
        write_reg(CFG_IMAGE_HEIGHT, '1);
        write_reg(CFG_WINDOW_MODE, CFG_W'(1));
        run_frame(FILL_EXTREME, 60, 1'b0);

        // random frames
        random_items = 0;
        frame_no     = 0;
        cut          = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (random_items < RANDOM_ITEMS / 3) begin
                src_gap_pct   = 20;
                snk_stall_pct = 84;
            end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
                src_gap_pct   = 84;
                snk_stall_pct = 20;
            end else begin
                src_gap_pct   = 0;
                snk_stall_pct = 0;
            end
            // an aborted frame always gets a register write before the next
            if (frame_no == 0 || cut != 0 || $urandom_range(1)) pick_config();
            if (frame_no % 10 == 1) hold_left = HOLD_CYCLES;
            case ($urandom_range(19))
                0, 1, 2: fill = FILL_FULL;
                3, 4:    fill = FILL_ZERO;
                5, 6, 7: fill = FILL_EXTREME;
                default: fill = FILL_RANDOM;
            endcase
            npix = sb.img_w * sb.img_h;
            cut  = ($urandom_range(9) == 0) ? $urandom_range(npix - 1, 1) : 0;
            run_frame(fill, cut, frame_no % 10 == 2);
            frame_no++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("box_mean_filter_3_or_5_test OK");
        else
            $display("box_mean_filter_3_or_5_test NOT OK");
        $finish;
    end

endmodule
